// File: rtl/kdcc_pkg.sv
// Package: types and constants for the key debounce and click classifier.
package kdcc_pkg;

  localparam int NUM_KEYS   = 3;
  localparam int MAX_EVENTS = 3;

  localparam logic [15:0] SAT16            = 16'hFFFF;
  localparam logic [15:0] DEBOUNCE_RESET   = 16'd20;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
  localparam logic [15:0] DOUBLE_WIN_RESET = 16'd200;

  localparam logic [1:0] EV_SINGLE = 2'd0;
  localparam logic [1:0] EV_DOUBLE = 2'd1;
  localparam logic [1:0] EV_LONG   = 2'd2;

  typedef enum logic [1:0] {
    REG_DEBOUNCE_TICKS   = 2'd0,
    REG_LONG_PRESS_MS    = 2'd1,
    REG_DOUBLE_WINDOW_MS = 2'd2,
    REG_UNUSED           = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]  key_levels;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  key_index;
    logic [1:0]  event_kind;
    logic [31:0] event_time;
    logic [15:0] held_ms;
    logic [15:0] gap_ms;
    logic        final_event;
  } out_item_t;

endpackage

// File: rtl/key_debounce_click_classifier_unit.sv
// Top level: per-key debounce and single/double/long click event generation.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one tick: raw key levels
//   and a millisecond timestamp. Output channel (out_valid/out_stall/out_data)
//   carries click events, in key order, final_event set on the last event of
//   a tick. A tick that causes no event produces no output item.
//   Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the debounce
//   count, long-press time and double-click window; cfg_ready is always high.
// Timing:
//   An accepted tick waits in the input register until the result buffer is
//   free; it is then classified and its events land in a three-entry result
//   buffer, from which they leave one per cycle while out_stall is low. The
//   single output port drains the buffer; the next tick is classified once it
//   is empty or its last event leaves, and a tick yields at most three events.
// Reset: synchronous rst clears all key state to released/idle, empties the
//   pipeline and loads the default register values.
// Stall: while out_stall holds, the buffered event stays on out_data; one more
//   tick is held in the input register, after which in_stall rises.
module key_debounce_click_classifier_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  kdcc_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output kdcc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import kdcc_pkg::*;

  localparam int NCAND = 2 * NUM_KEYS;

  // configuration
  logic [15:0] debounce_ticks;
  logic [15:0] long_press_ms;
  logic [15:0] double_window_ms;

  // per-key state
  logic        prev_raw       [NUM_KEYS];
  logic        stable_state   [NUM_KEYS];
  logic [15:0] stable_count   [NUM_KEYS];
  logic        waiting_second [NUM_KEYS];
  logic        long_done      [NUM_KEYS];
  logic        skip_release   [NUM_KEYS];
  logic [31:0] press_time     [NUM_KEYS];
  logic [31:0] release_time   [NUM_KEYS];

  logic        prev_raw_next       [NUM_KEYS];
  logic        stable_state_next   [NUM_KEYS];
  logic [15:0] stable_count_next   [NUM_KEYS];
  logic        waiting_second_next [NUM_KEYS];
  logic        long_done_next      [NUM_KEYS];
  logic        skip_release_next   [NUM_KEYS];
  logic [31:0] press_time_next     [NUM_KEYS];
  logic [31:0] release_time_next   [NUM_KEYS];

  // input register
  logic     p_valid;
  in_item_t p_item;

  // event candidates: per key, slot 0 is the edge event, slot 1 long or timeout
  logic      cand_v [NCAND];
  out_item_t cand_e [NCAND];

  out_item_t   slot  [MAX_EVENTS];
  logic [1:0]  n_ev;

  // result buffer
  out_item_t   ev [MAX_EVENTS];
  logic [1:0]  rem;
  logic [1:0]  rd;

  logic out_take;
  logic buf_free;
  logic fire;

  assign cfg_ready = 1'b1;
  assign out_valid = (rem != 2'd0);
  assign out_data  = ev[rd];
  assign out_take  = out_valid && !out_stall;
  assign buf_free  = (rem == 2'd0) || (rem == 2'd1 && out_take);
  assign fire      = p_valid && buf_free;
  assign in_stall  = p_valid && !buf_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_RESET;
      long_press_ms    <= LONG_PRESS_RESET;
      double_window_ms <= DOUBLE_WIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE_TICKS:   debounce_ticks   <= cfg_data;
        REG_LONG_PRESS_MS:    long_press_ms    <= cfg_data;
        REG_DOUBLE_WINDOW_MS: double_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      p_valid <= 1'b1;
    end else if (fire) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      p_item <= in_data;
    end
  end

  // per-key classification
  always_comb begin
    logic        lv;
    logic        edge_hit;
    logic        press_edge;
    logic        rel_edge;
    logic        set_rt;
    logic        w;
    logic        ld;
    logic        sk;
    logic [32:0] diff_r;
    logic [32:0] diff_p;
    logic [31:0] hold;
    logic [31:0] now;

    now = p_item.now_ms;
    for (int k = 0; k < NUM_KEYS; k++) begin
      lv = p_item.key_levels[k];

      prev_raw_next[k] = lv;
      if (lv == prev_raw[k]) begin
        stable_count_next[k] = (stable_count[k] < SAT16) ? stable_count[k] + 16'd1
                                                           : stable_count[k];
      end else begin
        stable_count_next[k] = '0;
      end

      edge_hit   = (stable_state[k] != lv) && (stable_count_next[k] >= debounce_ticks);
      press_edge = edge_hit && lv;
      rel_edge   = edge_hit && !lv;
      stable_state_next[k] = edge_hit ? lv : stable_state[k];

      diff_r = {1'b0, now} - {1'b0, release_time[k]};
      diff_p = {1'b0, now} - {1'b0, press_time[k]};

      w  = waiting_second[k];
      ld = long_done[k];
      sk = skip_release[k];
      set_rt = 1'b0;
      press_time_next[k]   = press_time[k];
      release_time_next[k] = release_time[k];

      cand_v[2*k]   = 1'b0;
      cand_v[2*k+1] = 1'b0;
      cand_e[2*k]   = '{key_index: 2'(k), event_kind: EV_SINGLE,
                        event_time: release_time[k], held_ms: '0, gap_ms: '0,
                        final_event: 1'b0};
      cand_e[2*k+1] = cand_e[2*k];

      if (press_edge) begin
        press_time_next[k] = now;
        ld = 1'b0;
        if (w) begin
          if (!diff_r[32]) begin
            cand_v[2*k] = 1'b1;
            if (diff_r[31:0] <= 32'(double_window_ms)) begin
              cand_e[2*k].event_kind = EV_DOUBLE;
              cand_e[2*k].event_time = now;
              cand_e[2*k].gap_ms     = diff_r[15:0];
              sk = 1'b1;
            end
          end
          w = 1'b0;
        end
      end

      if (rel_edge) begin
        if (sk) begin
          sk = 1'b0;
          w  = 1'b0;
        end else if (ld) begin
          w = 1'b0;
        end else if (!w) begin
          w = 1'b1;
          release_time_next[k] = now;
          set_rt = 1'b1;
        end
      end

      // a press on this tick measures zero hold time
      hold = press_edge ? 32'd0 : diff_p[31:0];
      if (stable_state_next[k] && !ld && !sk && (press_edge || !diff_p[32])) begin
        if (hold >= 32'(long_press_ms)) begin
          ld = 1'b1;
          w  = 1'b0;
          cand_v[2*k+1] = 1'b1;
          cand_e[2*k+1].event_kind = EV_LONG;
          cand_e[2*k+1].event_time = now;
          cand_e[2*k+1].held_ms    = long_press_ms;
        end
      end

      // release time stored this tick gives a zero gap: never a timeout
      if (w && !set_rt) begin
        if (diff_r[32]) begin
          w = 1'b0;
        end else if (diff_r[31:0] > 32'(double_window_ms)) begin
          w = 1'b0;
          cand_v[2*k+1] = 1'b1;
        end
      end

      waiting_second_next[k] = w;
      long_done_next[k]      = ld;
      skip_release_next[k]   = sk;
    end
  end

  // keep the first events in key order, drop the rest
  always_comb begin
    for (int j = 0; j < MAX_EVENTS; j++) begin
      slot[j] = cand_e[0];
    end
    n_ev = '0;
    for (int c = 0; c < NCAND; c++) begin
      if (cand_v[c] && n_ev != 2'(MAX_EVENTS)) begin
        slot[n_ev] = cand_e[c];
        n_ev = n_ev + 2'd1;
      end
    end
    for (int j = 0; j < MAX_EVENTS; j++) begin
      slot[j].final_event = (2'(j) + 2'd1 == n_ev);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        prev_raw[k]       <= 1'b0;
        stable_state[k]   <= 1'b0;
        stable_count[k]   <= '0;
        waiting_second[k] <= 1'b0;
        long_done[k]      <= 1'b0;
        skip_release[k]   <= 1'b0;
        press_time[k]     <= '0;
        release_time[k]   <= '0;
      end
    end else if (fire) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        prev_raw[k]       <= prev_raw_next[k];
        stable_state[k]   <= stable_state_next[k];
        stable_count[k]   <= stable_count_next[k];
        waiting_second[k] <= waiting_second_next[k];
        long_done[k]      <= long_done_next[k];
        skip_release[k]   <= skip_release_next[k];
        press_time[k]     <= press_time_next[k];
        release_time[k]   <= release_time_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      rd  <= '0;
    end else if (fire) begin
      rem <= n_ev;
      rd  <= '0;
    end else if (out_take) begin
      rem <= rem - 2'd1;
      if (rem > 2'd1) begin
        rd <= rd + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int j = 0; j < MAX_EVENTS; j++) begin
        ev[j] <= slot[j];
      end
    end
  end

endmodule
